// File: sv/radio_command_packet_filter_queue_unit_assert.svh
// Assertion macros for the radio command packet filter queue unit.
// Needs a clock named clock and a synchronous active-high reset named reset in scope.
`ifndef RADIO_COMMAND_PACKET_FILTER_QUEUE_UNIT_ASSERT_SVH
`define RADIO_COMMAND_PACKET_FILTER_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPFQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rcpfq: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCPFQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rcpfq: next-cycle check failed");

`endif

// File: sv/rcpfq_pkg.sv
// Package for the radio command packet filter queue unit.
// Holds status, kind and register codes, id constants, the queue entry type
// and the checksum function; it depends on nothing else.
`timescale 1ns / 1ps

package rcpfq_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_RECEIVE = 2'd0;
   localparam logic [1:0] KIND_SEND    = 2'd1;
   localparam logic [1:0] KIND_POP     = 2'd2;
   localparam logic [1:0] KIND_CLEAR   = 2'd3;

   // Result status codes.
   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_INVALID = 3'd1;
   localparam logic [2:0] STATUS_FULL    = 3'd2;
   localparam logic [2:0] STATUS_EMPTY   = 3'd3;
   localparam logic [2:0] STATUS_REFUSED = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_IS_MASTER   = 3'd0;
   localparam logic [2:0] CSR_RADIO_READY = 3'd1;
   localparam logic [2:0] CSR_HEADER_CODE = 3'd2;
   localparam logic [2:0] CSR_PING_CODE   = 3'd3;
   localparam logic [2:0] CSR_PONG_CODE   = 3'd4;

   // Node ids.
   localparam logic [7:0] MASTER_ID = 8'd1;
   localparam logic [7:0] SLAVE_ID  = 8'd2;

   // Register reset values.
   localparam logic       IS_MASTER_RESET   = 1'b1;
   localparam logic       RADIO_READY_RESET = 1'b0;
   localparam logic [7:0] HEADER_CODE_RESET = 8'd165;
   localparam logic [7:0] PING_CODE_RESET   = 8'd1;
   localparam logic [7:0] PONG_CODE_RESET   = 8'd2;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One queued command.
   typedef struct packed {
      logic [7:0] snd;
      logic [7:0] tgt;
      logic [7:0] cmd;
      logic [7:0] val;
      logic [7:0] seq;
   } entry_type;

   function automatic logic [7:0] xsum7(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input logic [7:0] e, input logic [7:0] f,
                                        input logic [7:0] g);
      return a ^ b ^ c ^ d ^ e ^ f ^ g;
   endfunction

endpackage

// File: sv/radio_command_packet_filter_queue_unit.sv
// Top level of the radio command packet filter queue unit.
// Depends on rcpfq_pkg and on the assertion macro header.
`timescale 1ns / 1ps
`include "radio_command_packet_filter_queue_unit_assert.svh"

// Usage:
// Each request on the req_ channel is a received packet, a send request, a pop or a
// queue clear, selected by req_kind. A request is taken at a rising edge where
// req_valid is high and req_stall is low. Every request yields exactly one result
// on the rsp_ channel, taken where rsp_valid is high and rsp_stall is low.
// The request is captured in an input register; when the output register can
// move, the filter, checksum and queue logic run and the result lands in the
// output register. One request per cycle is sustained while the receiver does not
// stall; the queue update runs between the input and output registers, with the
// queue head prefetched into a read register so that a pop never waits on the
// memory.
// When the receiver stalls, the output register holds its result and the input
// register can still take one more request; only when both are full does
// req_stall rise. Configuration writes through csr_ are taken at any edge but are
// meant to happen only while no request is in flight.
// Reset empties the queue, zeroes the send sequence and restores the register
// defaults (master role, link not ready, header 165, PING 1, PONG 2). The queue
// memory itself is not cleared; its entries are only read after being written.
module radio_command_packet_filter_queue_unit #(
   parameter int QUEUE_DEPTH = rcpfq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // Configuration write port.
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data,
   // Request channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_hdr,
   input  logic [7:0] req_sender,
   input  logic [7:0] req_target,
   input  logic [7:0] req_command,
   input  logic [7:0] req_payload_value,
   input  logic [7:0] req_sequence_req,
   input  logic [7:0] req_spare,
   input  logic [7:0] req_check,
   // Result channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_out_header,
   output logic [7:0] rsp_out_sender,
   output logic [7:0] rsp_out_target,
   output logic [7:0] rsp_out_cmd,
   output logic [7:0] rsp_out_value,
   output logic [7:0] rsp_out_seq,
   output logic [7:0] rsp_out_checksum,
   output logic [2:0] rsp_queue_count
);
   import rcpfq_pkg::*;

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   // Configuration registers.
   logic       is_master_ff;
   logic       radio_ready_ff;
   logic [7:0] header_code_ff;
   logic [7:0] ping_code_ff;
   logic [7:0] pong_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_master_ff   <= IS_MASTER_RESET;
         radio_ready_ff <= RADIO_READY_RESET;
         header_code_ff <= HEADER_CODE_RESET;
         ping_code_ff   <= PING_CODE_RESET;
         pong_code_ff   <= PONG_CODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IS_MASTER:   is_master_ff   <= csr_data[0];
            CSR_RADIO_READY: radio_ready_ff <= csr_data[0];
            CSR_HEADER_CODE: header_code_ff <= csr_data;
            CSR_PING_CODE:   ping_code_ff   <= csr_data;
            CSR_PONG_CODE:   pong_code_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline control. The output register moves whenever it is empty or taken;
   // the input register loads whenever it moves on or is empty.
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic load_s1;
   logic fire;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load_s1   = advance || !s1_valid_ff;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = !load_s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_s1) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Input register.
   logic [1:0] kind_ff;
   logic [7:0] hdr_ff, snd_ff, tgt_ff, cmd_ff, val_ff, seq_ff, spr_ff, chk_ff;

   always_ff @(posedge clock) begin
      if (load_s1 && req_valid) begin
         kind_ff <= req_kind;
         hdr_ff  <= req_hdr;
         snd_ff  <= req_sender;
         tgt_ff  <= req_target;
         cmd_ff  <= req_command;
         val_ff  <= req_payload_value;
         seq_ff  <= req_sequence_req;
         spr_ff  <= req_spare;
         chk_ff  <= req_check;
      end
   end

   // Queue state.
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [7:0]        send_seq_ff, send_seq_in;
   entry_type         queue_mem [0:QUEUE_DEPTH-1];
   entry_type         head_ff;
   entry_type         push_entry;
   logic              push;

   // Result next values.
   logic [2:0] status_in;
   logic [7:0] out_header_in, out_sender_in, out_target_in, out_cmd_in;
   logic [7:0] out_value_in, out_seq_in, out_checksum_in;
   logic [CNT_W+2:0] count_wide;

   logic [7:0] local_id, peer_id, want_cmd, allowed_cmd, rx_sum, tx_sum;
   logic       pkt_ok, send_ok;

   always_comb begin
      local_id    = is_master_ff ? MASTER_ID : SLAVE_ID;
      peer_id     = is_master_ff ? SLAVE_ID : MASTER_ID;
      want_cmd    = is_master_ff ? pong_code_ff : ping_code_ff;
      allowed_cmd = is_master_ff ? ping_code_ff : pong_code_ff;
      rx_sum      = xsum7(hdr_ff, snd_ff, tgt_ff, cmd_ff, val_ff, seq_ff, spr_ff);
      tx_sum      = xsum7(header_code_ff, local_id, peer_id, cmd_ff, val_ff,
                          send_seq_ff, 8'd0);
      pkt_ok = radio_ready_ff && (hdr_ff == header_code_ff) && (rx_sum == chk_ff) &&
               (snd_ff == peer_id) && (tgt_ff == local_id) &&
               (cmd_ff == want_cmd) && (val_ff != 8'd0);
      send_ok = radio_ready_ff && (val_ff != 8'd0) && (cmd_ff == allowed_cmd);

      push_entry = '{snd: snd_ff, tgt: tgt_ff, cmd: cmd_ff, val: val_ff, seq: seq_ff};
      push       = 1'b0;

      wr_slot_in  = wr_slot_ff;
      rd_slot_in  = rd_slot_ff;
      held_in     = held_ff;
      send_seq_in = send_seq_ff;

      status_in       = STATUS_OK;
      out_header_in   = 8'd0;
      out_sender_in   = 8'd0;
      out_target_in   = 8'd0;
      out_cmd_in      = 8'd0;
      out_value_in    = 8'd0;
      out_seq_in      = 8'd0;
      out_checksum_in = 8'd0;

      if (fire) begin
         unique case (kind_ff)
            KIND_RECEIVE: begin
               if (!pkt_ok) begin
                  status_in = STATUS_INVALID;
               end else if (held_ff == FULL_CNT) begin
                  status_in = STATUS_FULL;
               end else begin
                  push       = 1'b1;
                  wr_slot_in = (wr_slot_ff == LAST_SLOT) ? '0 : wr_slot_ff + 1'b1;
                  held_in    = held_ff + 1'b1;
               end
            end
            KIND_SEND: begin
               if (!send_ok) begin
                  status_in = STATUS_REFUSED;
               end else begin
                  send_seq_in     = send_seq_ff + 8'd1;
                  out_header_in   = header_code_ff;
                  out_sender_in   = local_id;
                  out_target_in   = peer_id;
                  out_cmd_in      = cmd_ff;
                  out_value_in    = val_ff;
                  out_seq_in      = send_seq_ff;
                  out_checksum_in = tx_sum;
               end
            end
            KIND_POP: begin
               if (held_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  out_sender_in = head_ff.snd;
                  out_target_in = head_ff.tgt;
                  out_cmd_in    = head_ff.cmd;
                  out_value_in  = head_ff.val;
                  out_seq_in    = head_ff.seq;
                  rd_slot_in    = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + 1'b1;
                  held_in       = held_ff - 1'b1;
               end
            end
            KIND_CLEAR: begin
               wr_slot_in = '0;
               rd_slot_in = '0;
               held_in    = '0;
            end
            default: ;
         endcase
      end

      count_wide = {3'b000, held_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff  <= '0;
         rd_slot_ff  <= '0;
         held_ff     <= '0;
         send_seq_ff <= 8'd0;
      end else begin
         wr_slot_ff  <= wr_slot_in;
         rd_slot_ff  <= rd_slot_in;
         held_ff     <= held_in;
         send_seq_ff <= send_seq_in;
      end
   end

   // Queue memory with one write port and one registered read port. The read
   // register always holds the entry at the next head slot, taking the entry
   // being written when the head and the write slot meet.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_slot_ff] <= push_entry;
      end
      if (push && (wr_slot_ff == rd_slot_in)) begin
         head_ff <= push_entry;
      end else begin
         head_ff <= queue_mem[rd_slot_in];
      end
   end

   // Output register.
   logic [2:0] rsp_status_ff, rsp_queue_count_ff;
   logic [7:0] rsp_out_header_ff, rsp_out_sender_ff, rsp_out_target_ff, rsp_out_cmd_ff;
   logic [7:0] rsp_out_value_ff, rsp_out_seq_ff, rsp_out_checksum_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff       <= status_in;
         rsp_out_header_ff   <= out_header_in;
         rsp_out_sender_ff   <= out_sender_in;
         rsp_out_target_ff   <= out_target_in;
         rsp_out_cmd_ff      <= out_cmd_in;
         rsp_out_value_ff    <= out_value_in;
         rsp_out_seq_ff      <= out_seq_in;
         rsp_out_checksum_ff <= out_checksum_in;
         rsp_queue_count_ff  <= count_wide[2:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_header   = rsp_out_header_ff;
   assign rsp_out_sender   = rsp_out_sender_ff;
   assign rsp_out_target   = rsp_out_target_ff;
   assign rsp_out_cmd      = rsp_out_cmd_ff;
   assign rsp_out_value    = rsp_out_value_ff;
   assign rsp_out_seq      = rsp_out_seq_ff;
   assign rsp_out_checksum = rsp_out_checksum_ff;
   assign rsp_queue_count  = rsp_queue_count_ff;

   // The held count never passes the queue depth.
   `RCPFQ_ASSERT_NOW(a_count_bound, 1'b1, held_ff <= FULL_CNT)
   // An empty or full queue has its read and write slots together.
   `RCPFQ_ASSERT_NOW(a_slots_meet, (held_ff == '0) || (held_ff == FULL_CNT),
                     wr_slot_ff == rd_slot_ff)
   // A clear leaves the queue empty with both slots at the start.
   `RCPFQ_ASSERT_NEXT(a_clear_empties, fire && (kind_ff == KIND_CLEAR),
                      (held_ff == '0) && (wr_slot_ff == '0) && (rd_slot_ff == '0))
   // Only a send request moves the send sequence.
   `RCPFQ_ASSERT_NEXT(a_seq_hold, !(fire && (kind_ff == KIND_SEND)),
                      send_seq_ff == $past(send_seq_ff))

endmodule

// File: bench/radio_command_packet_filter_queue_unit_test.sv
// Self-checking bench for the radio command packet filter queue unit.
// Drives receive, send, pop and clear requests, predicts every result in a small
// scoreboard class and compares field by field. Depends on rcpfq_pkg and the unit.
`timescale 1ns / 1ps

module radio_command_packet_filter_queue_unit_test;
   import rcpfq_pkg::*;

   // One request as the bench sees it, and one result.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] hdr, sender, target, command, value, seq, spare, check;
   } link_request_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] header, sender, target, cmd, value, seq, checksum;
      logic [2:0] count;
   } link_result_type;

   // The scoreboard keeps its own copy of the registers, the command queue and the
   // send sequence. Each accepted request is turned into the result it must cause,
   // and results from the unit are matched against those in order.
   class command_link_scoreboard;
      logic            is_master;
      logic            radio_ready;
      logic [7:0]      header_code, ping_code, pong_code;
      logic [7:0]      send_seq;
      entry_type       held_commands[$];
      link_result_type awaited_results[$];
      int              mismatch_count;

      function new();
         is_master = IS_MASTER_RESET;
         radio_ready = RADIO_READY_RESET;
         header_code = HEADER_CODE_RESET;
         ping_code = PING_CODE_RESET;
         pong_code = PONG_CODE_RESET;
         send_seq = 8'd0;
         mismatch_count = 0;
      endfunction

      function void set_register(input logic [2:0] index, input logic [7:0] data);
         case (index)
            CSR_IS_MASTER: is_master = data[0];
            CSR_RADIO_READY: radio_ready = data[0];
            CSR_HEADER_CODE: header_code = data;
            CSR_PING_CODE: ping_code = data;
            CSR_PONG_CODE: pong_code = data;
            default: ;
         endcase
      endfunction

      function link_result_type predict_link_result(input link_request_type r);
         link_result_type res;
         entry_type       e;
         logic [7:0]      local_id, peer_id, wanted_cmd, allowed_cmd;
         res = '0;
         local_id = is_master ? MASTER_ID : SLAVE_ID;
         peer_id = is_master ? SLAVE_ID : MASTER_ID;
         // A master listens for PONG and sends PING; a slave the other way round.
         wanted_cmd = is_master ? pong_code : ping_code;
         allowed_cmd = is_master ? ping_code : pong_code;
         case (r.kind)
            KIND_RECEIVE: begin
               if (!radio_ready || r.hdr != header_code ||
                   (r.hdr ^ r.sender ^ r.target ^ r.command ^ r.value ^ r.seq ^ r.spare)
                      != r.check ||
                   r.sender != peer_id || r.target != local_id ||
                   r.command != wanted_cmd || r.value == 8'd0) begin
                  res.status = STATUS_INVALID;
               end else if (held_commands.size() >= QUEUE_DEPTH_DEFAULT) begin
                  res.status = STATUS_FULL;
               end else begin
                  e.snd = r.sender;
                  e.tgt = r.target;
                  e.cmd = r.command;
                  e.val = r.value;
                  e.seq = r.seq;
                  held_commands.push_back(e);
                  res.status = STATUS_OK;
               end
            end
            KIND_SEND: begin
               if (!radio_ready || r.value == 8'd0 || r.command != allowed_cmd) begin
                  res.status = STATUS_REFUSED;
               end else begin
                  res.status = STATUS_OK;
                  res.header = header_code;
                  res.sender = local_id;
                  res.target = peer_id;
                  res.cmd = r.command;
                  res.value = r.value;
                  res.seq = send_seq;
                  // The reserved byte of a built packet is zero.
                  res.checksum = header_code ^ local_id ^ peer_id ^ r.command ^ r.value ^
                                 send_seq;
                  send_seq = send_seq + 8'd1;
               end
            end
            KIND_POP: begin
               if (held_commands.size() == 0) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  e = held_commands.pop_front();
                  res.status = STATUS_OK;
                  res.sender = e.snd;
                  res.target = e.tgt;
                  res.cmd = e.cmd;
                  res.value = e.val;
                  res.seq = e.seq;
               end
            end
            default: begin
               held_commands.delete();
               res.status = STATUS_OK;
            end
         endcase
         res.count = 3'(held_commands.size());
         return res;
      endfunction

      function void note_request(input link_request_type r);
         awaited_results.push_back(predict_link_result(r));
      endfunction

      task report(input string what);
         if (mismatch_count < 200) $display("[%0t] mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      task check_result(input link_result_type got);
         link_result_type want;
         if (awaited_results.size() == 0) begin
            report("result arrived with no request waiting for one");
         end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.header !== want.header)
               report($sformatf("out_header %h, expected %h", got.header, want.header));
            if (got.sender !== want.sender)
               report($sformatf("out_sender %h, expected %h", got.sender, want.sender));
            if (got.target !== want.target)
               report($sformatf("out_target %h, expected %h", got.target, want.target));
            if (got.cmd !== want.cmd)
               report($sformatf("out_cmd %h, expected %h", got.cmd, want.cmd));
            if (got.value !== want.value)
               report($sformatf("out_value %h, expected %h", got.value, want.value));
            if (got.seq !== want.seq)
               report($sformatf("out_seq %h, expected %h", got.seq, want.seq));
            if (got.checksum !== want.checksum)
               report($sformatf("out_checksum %h, expected %h", got.checksum,
                                want.checksum));
            if (got.count !== want.count)
               report($sformatf("queue_count %0d, expected %0d", got.count, want.count));
         end
      endtask
   endclass

   // Every input starts at a known value.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = '0;
   logic [7:0] req_hdr = '0;
   logic [7:0] req_sender = '0;
   logic [7:0] req_target = '0;
   logic [7:0] req_command = '0;
   logic [7:0] req_payload_value = '0;
   logic [7:0] req_sequence_req = '0;
   logic [7:0] req_spare = '0;
   logic [7:0] req_check = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_out_header;
   logic [7:0] rsp_out_sender;
   logic [7:0] rsp_out_target;
   logic [7:0] rsp_out_cmd;
   logic [7:0] rsp_out_value;
   logic [7:0] rsp_out_seq;
   logic [7:0] rsp_out_checksum;
   logic [2:0] rsp_queue_count;

   command_link_scoreboard link_board;

   // Request gaps come roughly once in this many requests, receiver stalls less
   // often; zero turns them off, which the final phase relies on to run at full rate.
   int idle_one_in = 0;

   radio_command_packet_filter_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH_DEFAULT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_hdr(req_hdr),
      .req_sender(req_sender),
      .req_target(req_target),
      .req_command(req_command),
      .req_payload_value(req_payload_value),
      .req_sequence_req(req_sequence_req),
      .req_spare(req_spare),
      .req_check(req_check),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_header(rsp_out_header),
      .rsp_out_sender(rsp_out_sender),
      .rsp_out_target(rsp_out_target),
      .rsp_out_cmd(rsp_out_cmd),
      .rsp_out_value(rsp_out_value),
      .rsp_out_seq(rsp_out_seq),
      .rsp_out_checksum(rsp_out_checksum),
      .rsp_queue_count(rsp_queue_count)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A fully random request; the shaped generators below start from this so that
   // the fields they do not set still see every bit pattern.
   function automatic link_request_type request_of_kind(input logic [1:0] kind);
      link_request_type r;
      r.kind = kind;
      r.hdr = 8'($urandom);
      r.sender = 8'($urandom);
      r.target = 8'($urandom);
      r.command = 8'($urandom);
      r.value = 8'($urandom);
      r.seq = 8'($urandom);
      r.spare = 8'($urandom);
      r.check = 8'($urandom);
      return r;
   endfunction

   // A packet that passes every filter check under the current role and codes.
   function automatic link_request_type well_formed_receive();
      link_request_type r;
      r = request_of_kind(KIND_RECEIVE);
      r.hdr = link_board.header_code;
      r.sender = link_board.is_master ? SLAVE_ID : MASTER_ID;
      r.target = link_board.is_master ? MASTER_ID : SLAVE_ID;
      r.command = link_board.is_master ? link_board.pong_code : link_board.ping_code;
      r.value = 8'($urandom_range(1, 255));
      r.check = r.hdr ^ r.sender ^ r.target ^ r.command ^ r.value ^ r.seq ^ r.spare;
      return r;
   endfunction

   // A well-formed packet with exactly one thing wrong. For a bad header, id,
   // command or value the checksum is redone, so only that one check trips.
   function automatic link_request_type broken_receive(input int flaw);
      link_request_type r;
      logic [7:0]       flip;
      r = well_formed_receive();
      flip = 8'($urandom_range(1, 255));
      case (flaw)
         0: r.hdr ^= flip;
         1: r.sender ^= flip;
         2: r.target ^= flip;
         3: r.command ^= flip;
         4: r.value = 8'd0;
         5: r.spare ^= flip;
         default: r.check ^= flip;
      endcase
      if (flaw <= 4)
         r.check = r.hdr ^ r.sender ^ r.target ^ r.command ^ r.value ^ r.seq ^ r.spare;
      return r;
   endfunction

   // A send request the role allows, with a nonzero value.
   function automatic link_request_type allowed_send();
      link_request_type r;
      r = request_of_kind(KIND_SEND);
      r.command = link_board.is_master ? link_board.ping_code : link_board.pong_code;
      r.value = 8'($urandom_range(1, 255));
      return r;
   endfunction

   // Mostly well-formed traffic so that the queue fills, drains and drops; sends
   // are frequent enough for the sequence number to wrap; the rest is noise.
   function automatic link_request_type random_request();
      link_request_type r;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
         r = well_formed_receive();
      end else if (pick < 40) begin
         r = broken_receive($urandom_range(0, 6));
      end else if (pick < 66) begin
         r = allowed_send();
         if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 1) r.value = 8'd0;
            else r.command = 8'($urandom);
         end
      end else if (pick < 88) begin
         r = request_of_kind(KIND_POP);
      end else if (pick < 92) begin
         r = request_of_kind(KIND_CLEAR);
      end else begin
         r = request_of_kind(2'($urandom_range(0, 3)));
      end
      return r;
   endfunction

   // Presents one request and holds it until the unit takes it. The request is
   // handed to the scoreboard at the edge where it is accepted. Valid is left high
   // on return so that back-to-back requests need no second assignment.
   task automatic drive_request(input link_request_type r);
      if (idle_one_in != 0 && $urandom_range(1, idle_one_in) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= r.kind;
      req_hdr <= r.hdr;
      req_sender <= r.sender;
      req_target <= r.target;
      req_command <= r.command;
      req_payload_value <= r.value;
      req_sequence_req <= r.seq;
      req_spare <= r.spare;
      req_check <= r.check;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      link_board.note_request(r);
   endtask

   // Drops valid and waits until every predicted result has come back and the
   // two register stages have emptied.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (link_board.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The write enable stays high across a run of writes and is dropped by the
   // caller, so it never gets two assignments at one edge.
   task automatic write_register(input logic [2:0] index, input logic [7:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      link_board.set_register(index, data);
   endtask

   // Brings the unit to idle and writes all five registers.
   task automatic apply_setting(input logic master, input logic ready,
                                input logic [7:0] header, input logic [7:0] ping,
                                input logic [7:0] pong);
      settle();
      write_register(CSR_IS_MASTER, {7'd0, master});
      write_register(CSR_RADIO_READY, {7'd0, ready});
      write_register(CSR_HEADER_CODE, header);
      write_register(CSR_PING_CODE, ping);
      write_register(CSR_PONG_CODE, pong);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Results are taken at every edge where valid is high and stall is low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         link_board.check_result(link_result_type'{rsp_status, rsp_out_header,
            rsp_out_sender, rsp_out_target, rsp_out_cmd, rsp_out_value, rsp_out_seq,
            rsp_out_checksum, rsp_queue_count});
   end

   // Receiver back-pressure in random bursts, about half as often as
   // the sender's gaps, and never while gaps are switched off.
   initial begin
      forever begin
         @(posedge clock);
         if (idle_one_in != 0 && $urandom_range(1, 2 * idle_one_in) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      link_request_type r;
      int               flaw;
      int               phase;

      link_board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Out of reset the link is not ready, so a perfect packet is
      // rejected, a send is refused and the queue is empty.
      idle_one_in = 4;
      drive_request(well_formed_receive());
      drive_request(allowed_send());
      drive_request(request_of_kind(KIND_POP));
      drive_request(request_of_kind(KIND_CLEAR));

      apply_setting(1'b1, 1'b1, HEADER_CODE_RESET, PING_CODE_RESET, PONG_CODE_RESET);
      // Fill the queue; the fifth packet is dropped because the queue is full.
      repeat (5) drive_request(well_formed_receive());
      // Drain it in order; the fifth pop finds it empty.
      repeat (5) drive_request(request_of_kind(KIND_POP));
      // One filter failure of each sort.
      for (flaw = 0; flaw < 7; flaw++) drive_request(broken_receive(flaw));
      // Sends: largest value, zero value, and a command the master may not send.
      r = allowed_send();
      r.value = 8'hFF;
      drive_request(r);
      r.value = 8'h00;
      drive_request(r);
      r = allowed_send();
      r.command = link_board.pong_code;
      drive_request(r);
      // Clear with an entry held, then pop from the cleared queue.
      drive_request(well_formed_receive());
      drive_request(request_of_kind(KIND_CLEAR));
      drive_request(request_of_kind(KIND_POP));

      // Random phases, each under its own register setting. The last one runs
      // with no gaps on either side.
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               apply_setting(1'b1, 1'b1, 8'hA5, 8'h01, 8'h02);
               idle_one_in = 3;
            end
            1: begin
               // Slave role with the code extremes.
               apply_setting(1'b0, 1'b1, 8'h00, 8'hFF, 8'h00);
               idle_one_in = 6;
            end
            2: begin
               // PING and PONG share a code; each check still uses its own register.
               apply_setting(1'b1, 1'b1, 8'hFF, 8'h3C, 8'h3C);
               idle_one_in = 12;
            end
            3: begin
               // Link down again: receives are skipped and every send is refused.
               apply_setting(1'b0, 1'b0, 8'h5A, 8'h10, 8'h20);
               idle_one_in = 5;
            end
            default: begin
               apply_setting(1'($urandom_range(0, 1)), 1'b1, 8'($urandom),
                             8'($urandom), 8'($urandom));
               idle_one_in = 0;
            end
         endcase
         repeat ((phase == 3) ? 100 : 330) drive_request(random_request());
      end

      settle();
      if (link_board.mismatch_count == 0) begin
         $display("radio_command_packet_filter_queue_unit test passed");
      end else begin
         $display("radio_command_packet_filter_queue_unit test failed");
      end
      $finish;
   end

   // Guard against a hung handshake or results that never arrive.
   initial begin
      #2_000_000;
      $display("radio_command_packet_filter_queue_unit test failed");
      $finish;
   end

endmodule
